// ----- sv/status_led_pattern_generator_macros.svh -----
// Assertion macros for the status LED pattern generator.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef STATUS_LED_PATTERN_GENERATOR_MACROS_SVH
`define STATUS_LED_PATTERN_GENERATOR_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SLPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SLPG_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/slpg_pkg.sv -----
// Shared types and constants of the status LED pattern generator.
// Used by every module of the block; depends on nothing.
package slpg_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned ModeW     = 4;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned FrameIntW = 10;
  localparam int unsigned BootHoldW = 14;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 14;
  localparam int unsigned RemW      = 9;   // every odd divisor is below 512
  localparam int unsigned DtLoW     = 5;   // widest power-of-two factor of a period
  localparam int unsigned PhaseW    = 12;
  localparam int unsigned MirrorW   = 11;
  localparam int unsigned RecipW    = 33;
  localparam int unsigned ProdW     = TimeW + RecipW;
  localparam int unsigned EnvKW     = 15;

  localparam logic [FrameIntW-1:0] FrameIntReset = 10'd33;
  localparam logic [BootHoldW-1:0] BootHoldReset = 14'd400;

  typedef enum logic [CmdW-1:0] {
    CmdStart   = 2'd0,
    CmdTick    = 2'd1,
    CmdSetMode = 2'd2,
    CmdSetApp  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameInterval = 1'b0,
    CfgBootHold      = 1'b1
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    ModeBoot         = 4'd0,
    ModeIdle         = 4'd1,
    ModeConnected    = 4'd2,
    ModeDisconnected = 4'd3,
    ModeListening    = 4'd4,
    ModeSpeaking     = 4'd5,
    ModeWalking      = 4'd6,
    ModeTripped      = 4'd7,
    ModeLowbatt      = 4'd8,
    ModeApp          = 4'd9
  } mode_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  localparam rgb_t ColBlack   = '{red: 8'd0,   green: 8'd0,  blue: 8'd0};
  localparam rgb_t ColBoot    = '{red: 8'd30,  green: 8'd25, blue: 8'd18};
  localparam rgb_t ColDisconn = '{red: 8'd60,  green: 8'd0,  blue: 8'd0};
  localparam rgb_t ColTripOn  = '{red: 8'd180, green: 8'd0,  blue: 8'd0};
  localparam rgb_t ColLowOn   = '{red: 8'd120, green: 8'd60, blue: 8'd0};
  localparam rgb_t ColLowOff  = '{red: 8'd25,  green: 8'd12, blue: 8'd0};

  // Reciprocals ceil(2^S / n): exact quotients for any 32-bit dividend.
  localparam logic [RecipW-1:0] Recip125 = 33'd4398046512;
  localparam logic [RecipW-1:0] Recip375 = 33'd5864062015;
  localparam logic [RecipW-1:0] Recip75  = 33'd7330077519;
  localparam logic [RecipW-1:0] Recip25  = 33'd5497558139;
  localparam int unsigned Shift125 = 39;
  localparam int unsigned Shift375 = 41;
  localparam int unsigned Shift75  = 39;
  localparam int unsigned Shift25  = 37;

  localparam logic [RemW-1:0] Div125 = 9'd125;
  localparam logic [RemW-1:0] Div375 = 9'd375;
  localparam logic [RemW-1:0] Div75  = 9'd75;
  localparam logic [RemW-1:0] Div25  = 9'd25;

  localparam logic [PhaseW-1:0] PerIdle   = 12'd4000;
  localparam logic [PhaseW-1:0] PerConn   = 12'd3000;
  localparam logic [PhaseW-1:0] PerListen = 12'd600;
  localparam logic [PhaseW-1:0] PerSpeak  = 12'd400;
  localparam logic [PhaseW-1:0] PerWalk   = 12'd1000;
  localparam logic [MirrorW-1:0] MirrorMax = 11'd2000;

  // Envelope step floor(2*amp*m/P) as (m * K) >> Sh, exact over the mirror range.
  localparam logic [EnvKW-1:0] EnvKIdle   = 15'd12585;
  localparam logic [EnvKW-1:0] EnvKConn   = 15'd2622;
  localparam logic [EnvKW-1:0] EnvKListen = 15'd342;
  localparam logic [EnvKW-1:0] EnvKSpeak  = 15'd29493;
  localparam logic [EnvKW-1:0] EnvKWalk   = 15'd820;
  localparam int unsigned EnvShIdle   = 20;
  localparam int unsigned EnvShConn   = 16;
  localparam int unsigned EnvShListen = 10;
  localparam int unsigned EnvShSpeak  = 16;
  localparam int unsigned EnvShWalk   = 12;
  localparam logic [ChanW-1:0] BaseIdle   = 8'd16;
  localparam logic [ChanW-1:0] BaseConn   = 8'd10;
  localparam logic [ChanW-1:0] BaseListen = 8'd25;
  localparam logic [ChanW-1:0] BaseSpeak  = 8'd40;
  localparam logic [ChanW-1:0] BaseWalk   = 8'd20;
  localparam logic [ChanW-1:0] LevelMax   = 8'd130;

  localparam int unsigned PctRecip = 5243;
  localparam int unsigned PctShift = 19;

  // Frame decided by the control stage.
  typedef struct packed {
    logic             vld;
    logic             fixed;
    mode_e            mode;
    logic [TimeW-1:0] dt;
    rgb_t             rgb;
  } frame_t;

  // Low bits of the scaled time and of its quotient by the odd divisor.
  typedef struct packed {
    logic             vld;
    logic             fixed;
    mode_e            mode;
    logic [RemW-1:0]  quo;
    logic [RemW-1:0]  num;
    logic [DtLoW-1:0] dt_lo;
    rgb_t             rgb;
  } quot_t;

  typedef struct packed {
    logic               vld;
    logic               fixed;
    mode_e              mode;
    logic [MirrorW-1:0] mirror;
    logic               odd;
    rgb_t               rgb;
  } phase_t;

  typedef struct packed {
    logic             vld;
    logic             fixed;
    mode_e            mode;
    logic [ChanW-1:0] level;
    logic             odd;
    rgb_t             rgb;
  } level_t;

  // floor(v * k / 100) through a reciprocal, exact while v * k stays below 43690.
  function automatic logic [ChanW-1:0] pct(input logic [ChanW-1:0] v, input int unsigned k);
    logic [31:0] prod;
    prod = 32'(v) * 32'(k * PctRecip);
    return ChanW'(prod >> PctShift);
  endfunction

endpackage

// ----- sv/slpg_ctrl.sv -----
// Control stage: mode state, frame rate cap, configuration registers.
// Depends on slpg_pkg and the assertion macro header.
`include "status_led_pattern_generator_macros.svh"

module slpg_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             in_valid_i,
  input  logic [slpg_pkg::CmdW-1:0]        cmd_i,
  input  logic [slpg_pkg::TimeW-1:0]       now_ms_i,
  input  logic [slpg_pkg::ModeW-1:0]       new_mode_i,
  input  logic [slpg_pkg::ChanW-1:0]       app_red_i,
  input  logic [slpg_pkg::ChanW-1:0]       app_green_i,
  input  logic [slpg_pkg::ChanW-1:0]       app_blue_i,
  input  logic                             cfg_valid_i,
  input  logic [slpg_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [slpg_pkg::CfgDataW-1:0]    cfg_data_i,
  output slpg_pkg::frame_t                 frame_o
);

  logic                              fire;
  logic                              started_q, started_d;
  slpg_pkg::mode_e                   mode_q, mode_d;
  slpg_pkg::mode_e                   painted_q, painted_d;
  logic [slpg_pkg::TimeW-1:0]        entered_q, entered_d;
  logic [slpg_pkg::TimeW-1:0]        last_frame_q, last_frame_d;
  slpg_pkg::rgb_t                    app_col_q, app_col_d;
  logic                              app_chg_q, app_chg_d;
  logic [slpg_pkg::FrameIntW-1:0]    frame_int_q;
  logic [slpg_pkg::BootHoldW-1:0]    boot_hold_q;
  logic [slpg_pkg::TimeW-1:0]        dt;
  logic [slpg_pkg::TimeW-1:0]        since;
  logic                              too_soon;
  slpg_pkg::frame_t                  frame_q, frame_d;

  assign fire     = in_valid_i && en_i;
  assign dt       = now_ms_i - entered_q;
  assign since    = now_ms_i - last_frame_q;
  assign too_soon = since < slpg_pkg::TimeW'(frame_int_q);

  always_comb begin
    started_d    = started_q;
    mode_d       = mode_q;
    painted_d    = painted_q;
    entered_d    = entered_q;
    last_frame_d = last_frame_q;
    app_col_d    = app_col_q;
    app_chg_d    = app_chg_q;
    frame_d       = '0;
    frame_d.mode  = mode_q;
    frame_d.dt    = dt;
    frame_d.rgb   = slpg_pkg::ColBlack;
    if (fire) begin
      unique case (slpg_pkg::cmd_e'(cmd_i))
        slpg_pkg::CmdStart: begin
          started_d     = 1'b1;
          entered_d     = now_ms_i;
          if (mode_q != slpg_pkg::ModeBoot) begin
            mode_d    = slpg_pkg::ModeBoot;
            painted_d = slpg_pkg::ModeBoot;
          end
          frame_d.vld   = 1'b1;
          frame_d.fixed = 1'b1;
        end
        slpg_pkg::CmdTick: begin
          if (started_q && !too_soon) begin
            last_frame_d = now_ms_i;
            unique case (mode_q)
              slpg_pkg::ModeBoot: begin
                if (dt < slpg_pkg::TimeW'(boot_hold_q)) begin
                  frame_d.vld   = 1'b1;
                  frame_d.fixed = 1'b1;
                  frame_d.rgb   = slpg_pkg::ColBoot;
                end else begin
                  // Boot hold expired: switch to idle without painting.
                  mode_d    = slpg_pkg::ModeIdle;
                  entered_d = now_ms_i;
                end
                painted_d = slpg_pkg::ModeBoot;
              end
              slpg_pkg::ModeApp: begin
                if (app_chg_q || painted_q != slpg_pkg::ModeApp) begin
                  frame_d.vld   = 1'b1;
                  frame_d.fixed = 1'b1;
                  frame_d.rgb   = app_col_q;
                  app_chg_d     = 1'b0;
                end
                painted_d = slpg_pkg::ModeApp;
              end
              slpg_pkg::ModeDisconnected: begin
                frame_d.vld   = 1'b1;
                frame_d.fixed = 1'b1;
                frame_d.rgb   = slpg_pkg::ColDisconn;
                painted_d     = mode_q;
              end
              default: begin
                frame_d.vld = 1'b1;
                painted_d   = mode_q;
              end
            endcase
          end
        end
        slpg_pkg::CmdSetMode: begin
          if (new_mode_i <= slpg_pkg::ModeApp &&
              slpg_pkg::mode_e'(new_mode_i) != mode_q) begin
            mode_d    = slpg_pkg::mode_e'(new_mode_i);
            entered_d = now_ms_i;
            painted_d = slpg_pkg::ModeBoot;
          end
        end
        slpg_pkg::CmdSetApp: begin
          app_col_d = '{red: app_red_i, green: app_green_i, blue: app_blue_i};
          app_chg_d = 1'b1;
          if (mode_q != slpg_pkg::ModeApp) begin
            mode_d    = slpg_pkg::ModeApp;
            entered_d = now_ms_i;
            painted_d = slpg_pkg::ModeBoot;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      mode_q       <= slpg_pkg::ModeBoot;
      painted_q    <= slpg_pkg::ModeBoot;
      entered_q    <= '0;
      last_frame_q <= '0;
      app_col_q    <= slpg_pkg::ColBlack;
      app_chg_q    <= 1'b0;
      frame_q      <= '0;
    end else begin
      started_q    <= started_d;
      mode_q       <= mode_d;
      painted_q    <= painted_d;
      entered_q    <= entered_d;
      last_frame_q <= last_frame_d;
      app_col_q    <= app_col_d;
      app_chg_q    <= app_chg_d;
      if (en_i) begin
        frame_q <= frame_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_int_q <= slpg_pkg::FrameIntReset;
      boot_hold_q <= slpg_pkg::BootHoldReset;
    end else if (cfg_valid_i) begin
      unique case (slpg_pkg::cfg_idx_e'(cfg_index_i))
        slpg_pkg::CfgFrameInterval: frame_int_q <= cfg_data_i[slpg_pkg::FrameIntW-1:0];
        slpg_pkg::CfgBootHold:      boot_hold_q <= cfg_data_i[slpg_pkg::BootHoldW-1:0];
      endcase
    end
  end

  assign frame_o = frame_q;

  `SLPG_ASSERT_NEXT(a_tick_before_start_silent,
    fire && cmd_i == slpg_pkg::CmdTick && !started_q,
    !frame_q.vld,
    "tick before start produced a frame")
  `SLPG_ASSERT(a_computed_frame_mode,
    (frame_q.vld && !frame_q.fixed) |-> (frame_q.mode != slpg_pkg::ModeBoot &&
      frame_q.mode != slpg_pkg::ModeDisconnected && frame_q.mode != slpg_pkg::ModeApp),
    "computed frame carries a fixed colour mode")
  `SLPG_ASSERT(a_mode_entry_clears_painted,
    (mode_q != $past(mode_q)) |-> (painted_q == slpg_pkg::ModeBoot),
    "mode changed without clearing the painted mode")

endmodule

// ----- sv/slpg_phase.sv -----
// Phase unit: reduces elapsed time modulo the mode period and mirrors it.
// Two register stages (reciprocal quotient, then remainder); depends on slpg_pkg.
`include "status_led_pattern_generator_macros.svh"

module slpg_phase (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  slpg_pkg::frame_t frame_i,
  output slpg_pkg::phase_t phase_o
);

  logic [slpg_pkg::TimeW-1:0]   num;
  logic [slpg_pkg::RecipW-1:0]  recip;
  logic [slpg_pkg::ProdW-1:0]   prod;
  logic [slpg_pkg::RemW-1:0]    quo;
  slpg_pkg::quot_t              quot_q, quot_d;

  logic [slpg_pkg::RemW-1:0]    divisor;
  logic [2*slpg_pkg::RemW-1:0]  qn;
  logic [slpg_pkg::RemW-1:0]    rem;
  logic [slpg_pkg::PhaseW-1:0]  ph;
  logic [slpg_pkg::PhaseW-1:0]  period;
  logic [slpg_pkg::PhaseW-1:0]  rest;
  slpg_pkg::phase_t             phase_q, phase_d;

  // Each period is 2^s times an odd divisor; only the odd part needs a division.
  always_comb begin
    unique case (frame_i.mode)
      slpg_pkg::ModeIdle: begin
        num   = frame_i.dt >> 5;
        recip = slpg_pkg::Recip125;
      end
      slpg_pkg::ModeConnected: begin
        num   = frame_i.dt >> 3;
        recip = slpg_pkg::Recip375;
      end
      slpg_pkg::ModeListening: begin
        num   = frame_i.dt >> 3;
        recip = slpg_pkg::Recip75;
      end
      slpg_pkg::ModeSpeaking: begin
        num   = frame_i.dt >> 4;
        recip = slpg_pkg::Recip25;
      end
      slpg_pkg::ModeWalking: begin
        num   = frame_i.dt >> 3;
        recip = slpg_pkg::Recip125;
      end
      slpg_pkg::ModeLowbatt: begin
        num   = frame_i.dt >> 2;
        recip = slpg_pkg::Recip125;
      end
      default: begin
        num   = frame_i.dt;
        recip = slpg_pkg::Recip125;
      end
    endcase
  end

  assign prod = {{slpg_pkg::RecipW{1'b0}}, num} * {{slpg_pkg::TimeW{1'b0}}, recip};

  always_comb begin
    unique case (frame_i.mode)
      slpg_pkg::ModeConnected: quo = prod[slpg_pkg::Shift375 +: slpg_pkg::RemW];
      slpg_pkg::ModeListening: quo = prod[slpg_pkg::Shift75 +: slpg_pkg::RemW];
      slpg_pkg::ModeSpeaking:  quo = prod[slpg_pkg::Shift25 +: slpg_pkg::RemW];
      default:                 quo = prod[slpg_pkg::Shift125 +: slpg_pkg::RemW];
    endcase
  end

  always_comb begin
    quot_d.vld   = frame_i.vld;
    quot_d.fixed = frame_i.fixed;
    quot_d.mode  = frame_i.mode;
    quot_d.quo   = quo;
    quot_d.num   = num[slpg_pkg::RemW-1:0];
    quot_d.dt_lo = frame_i.dt[slpg_pkg::DtLoW-1:0];
    quot_d.rgb   = frame_i.rgb;
  end

  // The remainder is below 512, so the low bits of num - quo*n give it exactly.
  always_comb begin
    unique case (quot_q.mode)
      slpg_pkg::ModeConnected: divisor = slpg_pkg::Div375;
      slpg_pkg::ModeListening: divisor = slpg_pkg::Div75;
      slpg_pkg::ModeSpeaking:  divisor = slpg_pkg::Div25;
      default:                 divisor = slpg_pkg::Div125;
    endcase
  end

  assign qn  = {{slpg_pkg::RemW{1'b0}}, quot_q.quo} * {{slpg_pkg::RemW{1'b0}}, divisor};
  assign rem = quot_q.num - qn[slpg_pkg::RemW-1:0];

  always_comb begin
    unique case (quot_q.mode)
      slpg_pkg::ModeIdle: begin
        ph     = {rem[6:0], quot_q.dt_lo};
        period = slpg_pkg::PerIdle;
      end
      slpg_pkg::ModeConnected: begin
        ph     = {rem, quot_q.dt_lo[2:0]};
        period = slpg_pkg::PerConn;
      end
      slpg_pkg::ModeListening: begin
        ph     = {2'b00, rem[6:0], quot_q.dt_lo[2:0]};
        period = slpg_pkg::PerListen;
      end
      slpg_pkg::ModeSpeaking: begin
        ph     = {3'b000, rem[4:0], quot_q.dt_lo[3:0]};
        period = slpg_pkg::PerSpeak;
      end
      slpg_pkg::ModeWalking: begin
        ph     = {2'b00, rem[6:0], quot_q.dt_lo[2:0]};
        period = slpg_pkg::PerWalk;
      end
      default: begin
        ph     = '0;
        period = '0;
      end
    endcase
  end

  assign rest = period - ph;

  always_comb begin
    phase_d.vld    = quot_q.vld;
    phase_d.fixed  = quot_q.fixed;
    phase_d.mode   = quot_q.mode;
    phase_d.mirror = (ph < rest) ? ph[slpg_pkg::MirrorW-1:0] : rest[slpg_pkg::MirrorW-1:0];
    // The divisor is odd, so the quotient parity is the parity of num - rem.
    phase_d.odd    = quot_q.num[0] ^ rem[0];
    phase_d.rgb    = quot_q.rgb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q  <= '0;
      phase_q <= '0;
    end else if (en_i) begin
      quot_q  <= quot_d;
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

  `SLPG_ASSERT(a_mirror_in_range,
    (phase_q.vld && !phase_q.fixed) |-> (phase_q.mirror <= slpg_pkg::MirrorMax),
    "mirrored phase exceeds half the longest period")

endmodule

// ----- sv/slpg_shade.sv -----
// Shading unit: envelope level, channel scaling and the output register.
// Depends on slpg_pkg and the assertion macro header.
`include "status_led_pattern_generator_macros.svh"

module slpg_shade (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  slpg_pkg::phase_t            phase_i,
  output logic                        out_valid_o,
  output logic [slpg_pkg::ChanW-1:0]  pixel_red_o,
  output logic [slpg_pkg::ChanW-1:0]  pixel_green_o,
  output logic [slpg_pkg::ChanW-1:0]  pixel_blue_o
);

  logic [slpg_pkg::EnvKW-1:0]  env_k;
  logic [slpg_pkg::ChanW-1:0]  base;
  logic [31:0]                 env_prod;
  logic [slpg_pkg::ChanW-1:0]  env;
  slpg_pkg::level_t            level_q, level_d;
  logic [slpg_pkg::ChanW-1:0]  v;
  slpg_pkg::rgb_t              pix_d, pix_q;
  logic                        out_vld_q;

  always_comb begin
    unique case (phase_i.mode)
      slpg_pkg::ModeIdle: begin
        env_k = slpg_pkg::EnvKIdle;
        base  = slpg_pkg::BaseIdle;
      end
      slpg_pkg::ModeConnected: begin
        env_k = slpg_pkg::EnvKConn;
        base  = slpg_pkg::BaseConn;
      end
      slpg_pkg::ModeListening: begin
        env_k = slpg_pkg::EnvKListen;
        base  = slpg_pkg::BaseListen;
      end
      slpg_pkg::ModeSpeaking: begin
        env_k = slpg_pkg::EnvKSpeak;
        base  = slpg_pkg::BaseSpeak;
      end
      slpg_pkg::ModeWalking: begin
        env_k = slpg_pkg::EnvKWalk;
        base  = slpg_pkg::BaseWalk;
      end
      default: begin
        env_k = '0;
        base  = '0;
      end
    endcase
  end

  assign env_prod = 32'(phase_i.mirror) * 32'(env_k);

  always_comb begin
    unique case (phase_i.mode)
      slpg_pkg::ModeIdle:      env = env_prod[slpg_pkg::EnvShIdle +: slpg_pkg::ChanW];
      slpg_pkg::ModeConnected: env = env_prod[slpg_pkg::EnvShConn +: slpg_pkg::ChanW];
      slpg_pkg::ModeListening: env = env_prod[slpg_pkg::EnvShListen +: slpg_pkg::ChanW];
      slpg_pkg::ModeSpeaking:  env = env_prod[slpg_pkg::EnvShSpeak +: slpg_pkg::ChanW];
      slpg_pkg::ModeWalking:   env = env_prod[slpg_pkg::EnvShWalk +: slpg_pkg::ChanW];
      default:                 env = '0;
    endcase
  end

  always_comb begin
    level_d.vld   = phase_i.vld;
    level_d.fixed = phase_i.fixed;
    level_d.mode  = phase_i.mode;
    level_d.level = base + env;
    level_d.odd   = phase_i.odd;
    level_d.rgb   = phase_i.rgb;
  end

  assign v = level_q.level;

  always_comb begin
    unique case (level_q.mode)
      slpg_pkg::ModeIdle:
        pix_d = '{red: v, green: slpg_pkg::pct(v, 85), blue: slpg_pkg::pct(v, 65)};
      slpg_pkg::ModeConnected:
        pix_d = '{red: slpg_pkg::pct(v, 15), green: v, blue: slpg_pkg::pct(v, 25)};
      slpg_pkg::ModeListening:
        pix_d = '{red: slpg_pkg::pct(v, 20), green: slpg_pkg::pct(v, 40), blue: v};
      slpg_pkg::ModeSpeaking:
        pix_d = '{red: '0, green: v, blue: v};
      slpg_pkg::ModeWalking:
        pix_d = '{red: '0, green: v, blue: slpg_pkg::pct(v, 15)};
      slpg_pkg::ModeTripped:
        pix_d = level_q.odd ? slpg_pkg::ColBlack : slpg_pkg::ColTripOn;
      slpg_pkg::ModeLowbatt:
        pix_d = level_q.odd ? slpg_pkg::ColLowOff : slpg_pkg::ColLowOn;
      default:
        pix_d = level_q.rgb;
    endcase
    if (level_q.fixed) begin
      pix_d = level_q.rgb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      level_q   <= level_d;
      out_vld_q <= level_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pixel_red_o   = pix_q.red;
  assign pixel_green_o = pix_q.green;
  assign pixel_blue_o  = pix_q.blue;

  `SLPG_ASSERT(a_level_in_range,
    (level_q.vld && !level_q.fixed && (level_q.mode == slpg_pkg::ModeIdle ||
      level_q.mode == slpg_pkg::ModeConnected || level_q.mode == slpg_pkg::ModeListening ||
      level_q.mode == slpg_pkg::ModeSpeaking || level_q.mode == slpg_pkg::ModeWalking))
      |-> (level_q.level <= slpg_pkg::LevelMax),
    "breathing level above its peak")

endmodule

// ----- sv/status_led_pattern_generator.sv -----
// Top level of the status LED pattern generator.
// Instantiates slpg_ctrl, slpg_phase and slpg_shade; depends on slpg_pkg.
//
// Usage: commands (start, tick, set mode, set app colour) enter on the input
// channel; a transaction is taken when in_valid_i is high and in_stall_o low.
// Start always yields a black pixel; a tick yields at most one pixel, and only
// when at least frame_interval_ms has passed since the last tick let through.
// Set mode and set app colour yield nothing. Pixels leave on the output channel,
// taken when out_valid_o is high and out_stall_i low.
// Throughput: one command per cycle while in_stall_o is low. A command that
// yields no pixel leaves a bubble in the five-register pipeline (control,
// quotient, phase, level, output), whose longest stage is the 32 by 33 bit
// reciprocal multiply in the quotient.
// A stalled output freezes the whole pipeline and raises in_stall_o in the same
// cycle, so nothing is lost; in_stall_o equals out_valid_o and out_stall_i.
// Configuration writes (0 frame interval, 1 boot hold) are always ready. The user
// must make them while no command is in flight; the block does not enforce this.
// Reset: mode boot, not started, no frame rendered, interval 33 ms, boot hold
// 400 ms, pipeline empty.

module status_led_pattern_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [slpg_pkg::CmdW-1:0]      cmd_i,
  input  logic [slpg_pkg::TimeW-1:0]     now_ms_i,
  input  logic [slpg_pkg::ModeW-1:0]     new_mode_i,
  input  logic [slpg_pkg::ChanW-1:0]     app_red_i,
  input  logic [slpg_pkg::ChanW-1:0]     app_green_i,
  input  logic [slpg_pkg::ChanW-1:0]     app_blue_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [slpg_pkg::ChanW-1:0]     pixel_red_o,
  output logic [slpg_pkg::ChanW-1:0]     pixel_green_o,
  output logic [slpg_pkg::ChanW-1:0]     pixel_blue_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [slpg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [slpg_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic             en;
  slpg_pkg::frame_t frame;
  slpg_pkg::phase_t phase;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  slpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .now_ms_i    (now_ms_i),
    .new_mode_i  (new_mode_i),
    .app_red_i   (app_red_i),
    .app_green_i (app_green_i),
    .app_blue_i  (app_blue_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .frame_o     (frame)
  );

  slpg_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .frame_i (frame),
    .phase_o (phase)
  );

  slpg_shade u_shade (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .phase_i       (phase),
    .out_valid_o   (out_valid_o),
    .pixel_red_o   (pixel_red_o),
    .pixel_green_o (pixel_green_o),
    .pixel_blue_o  (pixel_blue_o)
  );

endmodule

// ----- test/status_led_pattern_generator_tb.sv -----
// Self-checking testbench for the status LED pattern generator.
// A pixel scoreboard predicts every frame from its own copy of the mode state;
// needs slpg_pkg and the status_led_pattern_generator RTL.
`timescale 1ns / 1ps

module status_led_pattern_generator_tb;

  class pixel_scoreboard;
    slpg_pkg::rgb_t                      expected_q[$];
    int unsigned                         error_count;
    logic [slpg_pkg::FrameIntW-1:0]      frame_interval;
    logic [slpg_pkg::BootHoldW-1:0]      boot_hold;
    bit                                  started;
    slpg_pkg::mode_e                     mode;
    slpg_pkg::mode_e                     painted_mode;
    logic [slpg_pkg::TimeW-1:0]          entered_ms;
    logic [slpg_pkg::TimeW-1:0]          last_frame_ms;
    slpg_pkg::rgb_t                      app_colour;
    bit                                  app_dirty;

    function new();
      error_count    = 0;
      frame_interval = 10'd33;
      boot_hold      = 14'd400;
      started        = 1'b0;
      mode           = slpg_pkg::ModeBoot;
      painted_mode   = slpg_pkg::ModeBoot;
      entered_ms     = '0;
      last_frame_ms  = '0;
      app_colour     = '0;
      app_dirty      = 1'b0;
    endfunction

    function void write_reg(slpg_pkg::cfg_idx_e idx, logic [slpg_pkg::CfgDataW-1:0] data);
      if (idx == slpg_pkg::CfgFrameInterval) frame_interval = data[slpg_pkg::FrameIntW-1:0];
      else boot_hold = data;
    endfunction

    function slpg_pkg::rgb_t make_rgb(int unsigned r, int unsigned g, int unsigned b);
      slpg_pkg::rgb_t px;
      px.red   = 8'(r);
      px.green = 8'(g);
      px.blue  = 8'(b);
      return px;
    endfunction

    function void switch_mode(slpg_pkg::mode_e m, logic [slpg_pkg::TimeW-1:0] t);
      if (m == mode) return;
      mode         = m;
      entered_ms   = t;
      painted_mode = slpg_pkg::ModeBoot;
    endfunction

    // Triangle envelope: base plus amp scaled by the distance to the nearest period edge.
    function int unsigned breathe_level(logic [slpg_pkg::TimeW-1:0] dt, int unsigned period,
                                        int unsigned base, int unsigned amp);
      int unsigned ph;
      int unsigned mirror;
      ph     = dt % period;
      mirror = (ph < period - ph) ? ph : period - ph;
      return base + (amp * 2 * mirror) / period;
    endfunction

    function int unsigned scale(int unsigned v, int unsigned k);
      return (v * k) / 100;
    endfunction

    function bit paint_frame(logic [slpg_pkg::TimeW-1:0] t, output slpg_pkg::rgb_t px);
      logic [slpg_pkg::TimeW-1:0] dt;
      int unsigned                v;
      slpg_pkg::mode_e            m;
      bit                         has_px;
      dt     = t - entered_ms;
      m      = mode;
      has_px = 1'b1;
      px     = '0;
      case (m)
        slpg_pkg::ModeBoot: begin
          // Once the hold time is over, boot hands over to idle without a frame.
          if (dt < boot_hold) px = make_rgb(30, 25, 18);
          else begin
            switch_mode(slpg_pkg::ModeIdle, t);
            return 1'b0;
          end
        end
        slpg_pkg::ModeIdle: begin
          v  = breathe_level(dt, 4000, 16, 24);
          px = make_rgb(v, scale(v, 85), scale(v, 65));
        end
        slpg_pkg::ModeConnected: begin
          v  = breathe_level(dt, 3000, 10, 60);
          px = make_rgb(scale(v, 15), v, scale(v, 25));
        end
        slpg_pkg::ModeDisconnected: px = make_rgb(60, 0, 0);
        slpg_pkg::ModeListening: begin
          v  = breathe_level(dt, 600, 25, 100);
          px = make_rgb(scale(v, 20), scale(v, 40), v);
        end
        slpg_pkg::ModeSpeaking: begin
          v  = breathe_level(dt, 400, 40, 90);
          px = make_rgb(0, v, v);
        end
        slpg_pkg::ModeWalking: begin
          v  = breathe_level(dt, 1000, 20, 100);
          px = make_rgb(0, v, scale(v, 15));
        end
        slpg_pkg::ModeTripped: begin
          if (((dt / 125) & 1) == 0) px = make_rgb(180, 0, 0);
          else px = make_rgb(0, 0, 0);
        end
        slpg_pkg::ModeLowbatt: begin
          if (((dt / 500) & 1) == 0) px = make_rgb(120, 60, 0);
          else px = make_rgb(25, 12, 0);
        end
        default: begin
          // The app colour is repainted only when it is new or the mode was just entered.
          if (app_dirty || painted_mode != slpg_pkg::ModeApp) begin
            px        = app_colour;
            app_dirty = 1'b0;
          end else begin
            has_px = 1'b0;
          end
        end
      endcase
      painted_mode = m;
      return has_px;
    endfunction

    function void note_command(slpg_pkg::cmd_e c, logic [slpg_pkg::TimeW-1:0] t,
                               logic [slpg_pkg::ModeW-1:0] nm, slpg_pkg::rgb_t col);
      slpg_pkg::rgb_t px;
      case (c)
        slpg_pkg::CmdStart: begin
          started    = 1'b1;
          entered_ms = t;
          switch_mode(slpg_pkg::ModeBoot, t);
          expected_q.push_back(make_rgb(0, 0, 0));
        end
        slpg_pkg::CmdTick: begin
          if (started && slpg_pkg::TimeW'(t - last_frame_ms) >= frame_interval) begin
            last_frame_ms = t;
            if (paint_frame(t, px)) expected_q.push_back(px);
          end
        end
        slpg_pkg::CmdSetMode: begin
          if (nm <= slpg_pkg::ModeApp) switch_mode(slpg_pkg::mode_e'(nm), t);
        end
        default: begin
          app_colour = col;
          app_dirty  = 1'b1;
          switch_mode(slpg_pkg::ModeApp, t);
        end
      endcase
    endfunction

    function void check_pixel(slpg_pkg::rgb_t got);
      slpg_pkg::rgb_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected pixel (%0d,%0d,%0d)", got.red, got.green, got.blue);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red) begin
        $error("pixel_red mismatch: expected %0d, actual %0d", want.red, got.red);
        error_count++;
      end
      if (got.green !== want.green) begin
        $error("pixel_green mismatch: expected %0d, actual %0d", want.green, got.green);
        error_count++;
      end
      if (got.blue !== want.blue) begin
        $error("pixel_blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
        error_count++;
      end
    endfunction

    function bit drained();
      return expected_q.size() == 0;
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [slpg_pkg::CmdW-1:0]     cmd_i;
  logic [slpg_pkg::TimeW-1:0]    now_ms_i;
  logic [slpg_pkg::ModeW-1:0]    new_mode_i;
  logic [slpg_pkg::ChanW-1:0]    app_red_i;
  logic [slpg_pkg::ChanW-1:0]    app_green_i;
  logic [slpg_pkg::ChanW-1:0]    app_blue_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [slpg_pkg::ChanW-1:0]    pixel_red_o;
  logic [slpg_pkg::ChanW-1:0]    pixel_green_o;
  logic [slpg_pkg::ChanW-1:0]    pixel_blue_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [slpg_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [slpg_pkg::CfgDataW-1:0] cfg_data_i;

  pixel_scoreboard sb = new();

  int unsigned                burst_left = 0;
  int unsigned                gap_max    = 0;
  int unsigned                cur_fi     = 33;
  logic [slpg_pkg::TimeW-1:0] now_t      = '0;
  bit                         hold_req   = 1'b0;

  status_led_pattern_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .now_ms_i      (now_ms_i),
    .new_mode_i    (new_mode_i),
    .app_red_i     (app_red_i),
    .app_green_i   (app_green_i),
    .app_blue_i    (app_blue_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_red_o   (pixel_red_o),
    .pixel_green_o (pixel_green_o),
    .pixel_blue_o  (pixel_blue_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pixel('{red: pixel_red_o, green: pixel_green_o, blue: pixel_blue_o});
    end
  end

  // Receiver: stall patterns of random kind and length, plus one long hold on request.
  initial begin
    int unsigned kind;
    int unsigned span;
    int unsigned period;
    int unsigned hold_left;
    out_stall_i = 1'b0;
    hold_left   = 0;
    wait (rst_ni === 1'b1);
    forever begin
      kind   = $urandom_range(0, 3);
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 9);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (hold_left == 0 && hold_req) begin
          hold_left = 300;
          hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
          hold_left--;
          out_stall_i <= 1'b1;
        end else begin
          case (kind)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 99) < 30);
            2:       out_stall_i <= ($urandom_range(0, 99) < 70);
            default: out_stall_i <= ((k % period) < (period / 2));
          endcase
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_cmd(slpg_pkg::cmd_e c, logic [slpg_pkg::TimeW-1:0] t,
                          logic [slpg_pkg::ModeW-1:0] nm, slpg_pkg::rgb_t col);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      repeat ($urandom_range(0, gap_max)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    now_ms_i    <= t;
    new_mode_i  <= nm;
    app_red_i   <= col.red;
    app_green_i <= col.green;
    app_blue_i  <= col.blue;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c, t, nm, col);
  endtask

  task automatic write_cfg(slpg_pkg::cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= slpg_pkg::CfgDataW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, slpg_pkg::CfgDataW'(val));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Commands without a pixel may still be in the pipeline when the last pixel leaves.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (!sb.drained()) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned fi, int unsigned bh, int unsigned gaps,
                           int unsigned n_items, bit with_hold);
    int unsigned                roll;
    slpg_pkg::cmd_e             c;
    logic [slpg_pkg::TimeW-1:0] t;
    logic [slpg_pkg::ModeW-1:0] nm;
    slpg_pkg::rgb_t             col;
    drain();
    write_cfg(slpg_pkg::CfgFrameInterval, fi);
    write_cfg(slpg_pkg::CfgBootHold, bh);
    cur_fi  = fi;
    gap_max = gaps;
    if ($urandom_range(0, 1)) now_t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    else now_t = $urandom;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (with_hold && i == 40) hold_req = 1'b1;
      col  = 24'($urandom);
      nm   = slpg_pkg::ModeW'($urandom_range(0, 9));
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        // Noise: any command at any time with any mode number.
        c  = slpg_pkg::cmd_e'($urandom_range(0, 3));
        t  = $urandom;
        nm = slpg_pkg::ModeW'($urandom_range(0, 15));
      end else begin
        if ($urandom_range(0, 99) < 5) now_t += $urandom_range(0, 200000);
        else now_t += $urandom_range(0, 2 * cur_fi + 2);
        t    = now_t;
        roll = $urandom_range(0, 99);
        if (roll < 4) c = slpg_pkg::CmdStart;
        else if (roll < 78) c = slpg_pkg::CmdTick;
        else if (roll < 91) begin
          c = slpg_pkg::CmdSetMode;
          if ($urandom_range(0, 9) == 0) nm = slpg_pkg::ModeW'($urandom_range(10, 15));
        end else c = slpg_pkg::CmdSetApp;
      end
      send_cmd(c, t, nm, col);
    end
  endtask

  initial begin
    slpg_pkg::rgb_t none;
    none        = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = slpg_pkg::CmdStart;
    now_ms_i    = '0;
    new_mode_i  = '0;
    app_red_i   = '0;
    app_green_i = '0;
    app_blue_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = slpg_pkg::CfgFrameInterval;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset configuration.
    gap_max = 2;
    send_cmd(slpg_pkg::CmdTick, 32'd100, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetApp, 32'd120, 4'd0, '{red: 8'hFF, green: 8'h00, blue: 8'hAA});
    send_cmd(slpg_pkg::CmdSetMode, 32'd130, 4'd15, none);
    send_cmd(slpg_pkg::CmdStart, 32'hFFFF_FF00, 4'd0, none);
    send_cmd(slpg_pkg::CmdTick, 32'hFFFF_FFFF, 4'd0, none);
    send_cmd(slpg_pkg::CmdTick, 32'h0000_0005, 4'd0, none);
    send_cmd(slpg_pkg::CmdTick, 32'h0000_0090, 4'd0, none);
    send_cmd(slpg_pkg::CmdTick, 32'h0000_00C0, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd3000, slpg_pkg::ModeConnected, none);
    send_cmd(slpg_pkg::CmdTick, 32'd4500, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd5000, slpg_pkg::ModeDisconnected, none);
    send_cmd(slpg_pkg::CmdTick, 32'd5100, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd6000, slpg_pkg::ModeListening, none);
    send_cmd(slpg_pkg::CmdTick, 32'd6300, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd7000, slpg_pkg::ModeSpeaking, none);
    send_cmd(slpg_pkg::CmdTick, 32'd7200, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd8000, slpg_pkg::ModeWalking, none);
    send_cmd(slpg_pkg::CmdTick, 32'd8500, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd9000, slpg_pkg::ModeTripped, none);
    send_cmd(slpg_pkg::CmdTick, 32'd9100, 4'd0, none);
    send_cmd(slpg_pkg::CmdTick, 32'd9200, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd10000, slpg_pkg::ModeLowbatt, none);
    send_cmd(slpg_pkg::CmdTick, 32'd10600, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetApp, 32'd11000, 4'd0, '{red: 8'h00, green: 8'hFF, blue: 8'h55});
    send_cmd(slpg_pkg::CmdTick, 32'd11100, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd11150, slpg_pkg::ModeApp, none);
    send_cmd(slpg_pkg::CmdTick, 32'd11200, 4'd0, none);
    send_cmd(slpg_pkg::CmdSetMode, 32'd11400, slpg_pkg::ModeBoot, none);
    send_cmd(slpg_pkg::CmdTick, 32'd11500, 4'd0, none);

    // Random part, one setting per phase with the extremes first.
    run_phase(1, 1, 0, 200, 1'b0);
    run_phase(1000, 10000, 6, 200, 1'b0);
    run_phase(33, 400, 3, 250, 1'b1);
    run_phase($urandom_range(1, 1000), $urandom_range(1, 10000), 8, 200, 1'b0);
    run_phase($urandom_range(1, 60), $urandom_range(1, 2000), 2, 200, 1'b0);
    run_phase($urandom_range(1, 200), $urandom_range(1, 10000), 4, 200, 1'b0);
    drain();

    if (sb.error_count == 0 && sb.drained()) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
